// ===== rtl/pcs16_pkg.sv =====
package pcs16_pkg;

    // supported sample sizes
    localparam logic [6:0] BITS_8  = 7'd8;
    localparam logic [6:0] BITS_12 = 7'd12;
    localparam logic [6:0] BITS_16 = 7'd16;
    localparam logic [6:0] BITS_24 = 7'd24;
    localparam logic [6:0] BITS_32 = 7'd32;
    localparam logic [6:0] BITS_64 = 7'd64;

    // register indexes
    localparam logic CFG_SAMPLE_BITS   = 1'b0;
    localparam logic CFG_FLOAT_SAMPLES = 1'b1;

    localparam logic [6:0] SAMPLE_BITS_RST = BITS_16;

    // datapath widths: 53-bit significand, product by 32767 is 68 bits
    localparam int MANT_W = 53;
    localparam int PROD_W = MANT_W + 15;
    localparam int RND_W  = PROD_W + 1;

    // exponent offsets: bias plus fraction bits, single left-aligned to 53 bits
    localparam logic signed [12:0] SGL_K_OFS = 13'sd179;
    localparam logic signed [12:0] DBL_K_OFS = 13'sd1075;

    // rounding positions for single and double, by product msb
    localparam logic [5:0] DBL_RND_LO = 6'd14;
    localparam logic [5:0] DBL_RND_HI = 6'd15;
    localparam logic [5:0] SGL_RND_LO = 6'd43;
    localparam logic [5:0] SGL_RND_HI = 6'd44;

    localparam logic [15:0] S16_MAX = 16'h7FFF;
    localparam logic [15:0] S16_MIN = 16'h8000;

    typedef struct packed {
        logic        ok;
        logic        is_flt;
        logic        dbl;
        logic [15:0] int_sample;
        logic        neg;
        logic        sat;
        logic        zero;
        logic [6:0]  shamt;
    } t_ctl;

    typedef struct packed {
        logic              vld;
        t_ctl              ctl;
        logic [RND_W-1:0]  data;
    } t_stage;

endpackage

// ===== rtl/pcs16_decode.sv =====
module pcs16_decode (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic [63:0]          i_raw_word,
    input  logic [6:0]           i_sample_bits,
    input  logic                 i_float_samples,
    output pcs16_pkg::t_stage    o_stage
);

    pcs16_pkg::t_ctl                    n_ctl, r_ctl;
    logic [pcs16_pkg::MANT_W-1:0]       n_mant, r_mant;
    logic                               r_vld;
    logic signed [12:0]                 k;
    logic                               nan_v, inf_v, exp0;

    // field split and exponent to shift amount
    always_comb begin
        n_ctl = '0;
        n_mant = '0;
        k = '0;
        nan_v = 1'b0;
        inf_v = 1'b0;
        exp0 = 1'b0;
        n_ctl.ok = 1'b1;
        case (i_sample_bits)
            pcs16_pkg::BITS_8: begin
                n_ctl.int_sample = {i_raw_word[7:0], 8'h00};
            end
            pcs16_pkg::BITS_12, pcs16_pkg::BITS_16: begin
                n_ctl.int_sample = i_raw_word[15:0];
            end
            pcs16_pkg::BITS_24: begin
                n_ctl.int_sample = i_raw_word[23:8];
            end
            pcs16_pkg::BITS_32: begin
                if (i_float_samples) begin
                    n_ctl.is_flt = 1'b1;
                    n_ctl.neg = i_raw_word[31];
                    n_mant = {1'b1, i_raw_word[22:0], 29'd0};
                    nan_v = (i_raw_word[30:23] == 8'hFF) && (i_raw_word[22:0] != '0);
                    inf_v = (i_raw_word[30:23] == 8'hFF) && (i_raw_word[22:0] == '0);
                    exp0 = (i_raw_word[30:23] == 8'h00);
                    k = pcs16_pkg::SGL_K_OFS - $signed({5'd0, i_raw_word[30:23]});
                end else begin
                    n_ctl.int_sample = i_raw_word[31:16];
                end
            end
            pcs16_pkg::BITS_64: begin
                n_ctl.is_flt = 1'b1;
                n_ctl.dbl = 1'b1;
                n_ctl.neg = i_raw_word[63];
                n_mant = {1'b1, i_raw_word[51:0]};
                nan_v = (i_raw_word[62:52] == 11'h7FF) && (i_raw_word[51:0] != '0);
                inf_v = (i_raw_word[62:52] == 11'h7FF) && (i_raw_word[51:0] == '0);
                exp0 = (i_raw_word[62:52] == 11'h000);
                k = pcs16_pkg::DBL_K_OFS - $signed({2'd0, i_raw_word[62:52]});
            end
            default: begin
                n_ctl.ok = 1'b0;
            end
        endcase
        // huge values saturate, tiny values and nan give zero
        n_ctl.sat = inf_v || (k <= 13'sd0);
        n_ctl.zero = nan_v || exp0 || (k >= 13'sd69);
        n_ctl.shamt = k[6:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl <= n_ctl;
            r_mant <= n_mant;
        end
    end

    assign o_stage.vld = r_vld;
    assign o_stage.ctl = r_ctl;
    assign o_stage.data = {{(pcs16_pkg::RND_W - pcs16_pkg::MANT_W){1'b0}}, r_mant};

endmodule

// ===== rtl/pcs16_round.sv =====
module pcs16_round (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  pcs16_pkg::t_stage    i_stage,
    output pcs16_pkg::t_stage    o_stage
);

    localparam int PW = pcs16_pkg::PROD_W;
    localparam int RW = pcs16_pkg::RND_W;

    logic                    r_vld_q, r_vld_r;
    pcs16_pkg::t_ctl         r_ctl_q, r_ctl_r;
    logic [PW-1:0]           n_prod, r_prod;
    logic [RW-1:0]           n_rnd, r_rnd;
    logic [pcs16_pkg::MANT_W-1:0] mant;
    logic [5:0]              pos;
    logic [PW-1:0]           mask, half, low;
    logic                    up;

    // product by 32767 as (m << 15) - m
    assign mant = i_stage.data[pcs16_pkg::MANT_W-1:0];
    assign n_prod = {mant, 15'd0} - PW'(mant);

    // round to nearest even at the significand's last place
    always_comb begin
        if (r_ctl_q.dbl) begin
            pos = r_prod[PW-1] ? pcs16_pkg::DBL_RND_HI : pcs16_pkg::DBL_RND_LO;
        end else begin
            pos = r_prod[PW-1] ? pcs16_pkg::SGL_RND_HI : pcs16_pkg::SGL_RND_LO;
        end
        mask = (PW'(1) << pos) - PW'(1);
        half = PW'(1) << (pos - 6'd1);
        low = r_prod & mask;
        up = (low > half) || ((low == half) && r_prod[pos]);
        n_rnd = RW'(r_prod & ~mask) + (up ? RW'(PW'(1) << pos) : RW'(0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_q <= 1'b0;
            r_vld_r <= 1'b0;
        end else if (i_en) begin
            r_vld_q <= i_stage.vld;
            r_vld_r <= r_vld_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl_q <= i_stage.ctl;
            r_prod <= n_prod;
            r_ctl_r <= r_ctl_q;
            r_rnd <= n_rnd;
        end
    end

    assign o_stage.vld = r_vld_r;
    assign o_stage.ctl = r_ctl_r;
    assign o_stage.data = r_rnd;

endmodule

// ===== rtl/pcs16_scale.sv =====
module pcs16_scale (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  pcs16_pkg::t_stage    i_stage,
    output logic                 o_vld,
    output logic [15:0]          o_sample,
    output logic                 o_ok
);

    logic                          r_vld;
    logic [15:0]                   n_sample, r_sample;
    logic                          r_ok;
    logic [pcs16_pkg::RND_W-1:0]   big;
    logic                          over;
    logic [15:0]                   mag;

    // float samples: integer part, then clamp to the 16-bit range by sign
    always_comb begin
        big = i_stage.data >> i_stage.ctl.shamt;
        over = |big[pcs16_pkg::RND_W-1:16];
        mag = big[15:0];
        if (!i_stage.ctl.ok) begin
            n_sample = '0;
        end else if (!i_stage.ctl.is_flt) begin
            n_sample = i_stage.ctl.int_sample;
        end else if (i_stage.ctl.zero) begin
            n_sample = '0;
        end else if (!i_stage.ctl.neg) begin
            n_sample = (i_stage.ctl.sat || over || mag >= pcs16_pkg::S16_MAX)
                ? pcs16_pkg::S16_MAX : mag;
        end else begin
            n_sample = (i_stage.ctl.sat || over || mag >= pcs16_pkg::S16_MIN)
                ? pcs16_pkg::S16_MIN : 16'(-mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_stage.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sample <= n_sample;
            r_ok <= i_stage.ctl.ok;
        end
    end

    assign o_vld = r_vld;
    assign o_sample = r_sample;
    assign o_ok = r_ok;

endmodule

// ===== rtl/pcm_sample_to_int16.sv =====
// channel  | valid        | ready        | payload
// input    | i_in_valid   | o_in_ready   | i_raw_word
// output   | o_out_valid  | i_out_ready  | o_sample, o_ok
// config   | i_cfg_we     | -            | i_cfg_idx, i_cfg_data
//
// four register stages: decode, product, round, scale and clamp
// one transaction per cycle sustained while the output is not stalled
// the whole pipeline advances when the output register is empty or taken
// synchronous active-low reset clears valid bits and sets config to 16-bit integer samples
module pcm_sample_to_int16 (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [63:0]          i_raw_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic signed [15:0]   o_sample,
    output logic                 o_ok,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [6:0]           i_cfg_data
);

    logic [6:0]          r_sample_bits;
    logic                r_float_samples;
    logic                en;
    logic [15:0]         sample_u;
    pcs16_pkg::t_stage   s_dec, s_rnd;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_bits <= pcs16_pkg::SAMPLE_BITS_RST;
            r_float_samples <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == pcs16_pkg::CFG_SAMPLE_BITS) begin
                r_sample_bits <= i_cfg_data;
            end else begin
                r_float_samples <= i_cfg_data[0];
            end
        end
    end

    // global advance
    assign en = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    pcs16_decode u_decode (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (en),
        .i_vld           (i_in_valid),
        .i_raw_word      (i_raw_word),
        .i_sample_bits   (r_sample_bits),
        .i_float_samples (r_float_samples),
        .o_stage         (s_dec)
    );

    pcs16_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_stage (s_dec),
        .o_stage (s_rnd)
    );

    pcs16_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_stage  (s_rnd),
        .o_vld    (o_out_valid),
        .o_sample (sample_u),
        .o_ok     (o_ok)
    );

    assign o_sample = $signed(sample_u);

endmodule

// ===== rtl/pcs16_chk.sv =====
module pcs16_chk (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          o_in_ready,
    input  logic          o_out_valid,
    input  logic          i_out_ready,
    input  logic [15:0]   o_sample,
    input  logic          o_ok
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_sample) && $stable(o_ok))
        else $error("result changed under stall");

    // unsupported size gives zero
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_ok |-> o_sample == 16'd0)
        else $error("nonzero sample with ok low");

    // input side moves exactly when the output register frees
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("ready does not track output stall");

    // reset empties the pipeline
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("valid after reset");

endmodule

bind pcm_sample_to_int16 pcs16_chk u_pcs16_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_sample    (o_sample),
    .o_ok        (o_ok)
);

// ===== dv/pcm_sample_to_int16_tb.sv =====
module pcm_sample_to_int16_tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] sample;
        logic        ok;
    } t_conv;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [63:0]        i_raw_word = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [15:0] o_sample;
    logic               o_ok;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_idx = 1'b0;
    logic [6:0]         i_cfg_data = '0;

    // mirror of the block's configuration
    logic [6:0] cur_bits = pcs16_pkg::SAMPLE_BITS_RST;
    logic       cur_float = 1'b0;

    logic [63:0] word_q[$];
    t_conv       conv_q[$];
    int          fail_cnt = 0;
    logic        in_taken = 1'b0;
    logic        no_idle = 1'b0;
    logic        hold_req = 1'b0;
    logic        hold_done = 1'b0;
    int          hold_cnt = 0;
    int          in_gap = 0;
    int          out_gap = 0;
    int          stuck_cnt = 0;

    pcm_sample_to_int16 DUT (.*);

    always #2 i_clk = ~i_clk;

    function automatic real pow2(int k);
        return $bitstoreal({1'b0, 11'(k + 1023), 52'b0});
    endfunction

    // float product magnitude to int16: truncate toward zero, saturate
    function automatic logic [15:0] clamp_mag(real r, logic neg);
        int v;
        if (neg) begin
            if (r >= 32768.0) return pcs16_pkg::S16_MIN;
            v = -$rtoi(r);
        end else begin
            if (r >= 32767.0) return pcs16_pkg::S16_MAX;
            v = $rtoi(r);
        end
        return 16'(v);
    endfunction

    // round a positive magnitude in [0.5, 32768) to single precision, nearest even
    function automatic real to_single(real p);
        int  k;
        int  fl;
        real ulp;
        real q;
        k = 15;
        while (p < pow2(k)) k--;
        ulp = pow2(k - 23);
        q = p / ulp;
        fl = $rtoi(q);
        if ((q - fl) > 0.5 || ((q - fl) == 0.5 && fl[0])) fl++;
        return fl * ulp;
    endfunction

    function automatic t_conv convert_word(logic [63:0] raw, logic [6:0] bits, logic flt);
        t_conv r;
        real   p;
        r.ok = 1'b1;
        r.sample = '0;
        case (bits)
            pcs16_pkg::BITS_8: r.sample = {raw[7:0], 8'h00};
            pcs16_pkg::BITS_12, pcs16_pkg::BITS_16: r.sample = raw[15:0];
            pcs16_pkg::BITS_24: r.sample = raw[23:8];
            pcs16_pkg::BITS_32: begin
                if (!flt) begin
                    r.sample = raw[31:16];
                end else if (raw[30:23] == 8'hFF) begin
                    if (raw[22:0] == 0)
                        r.sample = raw[31] ? pcs16_pkg::S16_MIN : pcs16_pkg::S16_MAX;
                end else if (raw[30:23] != 0) begin
                    // exact product in double, then one rounding to single
                    p = real'({1'b1, raw[22:0]}) * 32767.0 * pow2(int'(raw[30:23]) - 150);
                    if (p >= 32768.0)
                        r.sample = raw[31] ? pcs16_pkg::S16_MIN : pcs16_pkg::S16_MAX;
                    else if (p >= 0.5) r.sample = clamp_mag(to_single(p), raw[31]);
                end
            end
            pcs16_pkg::BITS_64: begin
                if (raw[62:52] == 11'h7FF) begin
                    if (raw[51:0] == 0)
                        r.sample = raw[63] ? pcs16_pkg::S16_MIN : pcs16_pkg::S16_MAX;
                end else if (raw[62:52] >= 11'd1039) begin
                    r.sample = raw[63] ? pcs16_pkg::S16_MIN : pcs16_pkg::S16_MAX;
                end else if (raw[62:52] != 0) begin
                    p = $bitstoreal({1'b0, raw[62:0]}) * 32767.0;
                    r.sample = clamp_mag(p, raw[63]);
                end
            end
            default: r.ok = 1'b0;
        endcase
        return r;
    endfunction

    function automatic int rand_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // random word shaped for the current mode
    function automatic logic [63:0] rand_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        if ($urandom_range(0, 3) == 0) return w;
        if (cur_bits == pcs16_pkg::BITS_32 && cur_float) begin
            w[30:23] = 8'($urandom_range(110, 142));
            if ($urandom_range(0, 9) == 0) w[30:23] = 8'hFF;
        end else if (cur_bits == pcs16_pkg::BITS_64) begin
            w[62:52] = 11'($urandom_range(1005, 1040));
            if ($urandom_range(0, 9) == 0) w[62:52] = 11'h7FF;
        end
        return w;
    endfunction

    // input driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (word_q.size() > 0) begin
                i_raw_word <= word_q.pop_front();
                i_in_valid <= 1'b1;
                in_gap <= rand_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output ready, with one long hold-off
    always @(negedge i_clk) begin
        if (hold_req && !hold_done && hold_cnt == 0) begin
            hold_cnt <= 300;
            hold_done <= 1'b1;
            i_out_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_out_ready <= (hold_cnt == 1);
        end else if (out_gap > 0) begin
            out_gap <= out_gap - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            out_gap <= rand_gap();
        end
    end

    // monitor: predict on input transaction, check on output transaction
    always @(posedge i_clk) begin
        t_conv exp_r;
        in_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                conv_q.push_back(convert_word(i_raw_word, cur_bits, cur_float));
            if (o_out_valid && i_out_ready) begin
                if (conv_q.size() == 0) begin
                    $error("unexpected output transaction sample=%h ok=%b", o_sample, o_ok);
                    fail_cnt++;
                end else begin
                    exp_r = conv_q.pop_front();
                    if (o_sample !== exp_r.sample) begin
                        $error("sample: expected %h actual %h", exp_r.sample, o_sample);
                        fail_cnt++;
                    end
                    if (o_ok !== exp_r.ok) begin
                        $error("ok: expected %b actual %b", exp_r.ok, o_ok);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    // watchdog on cycles without progress while work is pending
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (word_q.size() == 0 && conv_q.size() == 0 && !i_in_valid))
            stuck_cnt <= 0;
        else
            stuck_cnt <= stuck_cnt + 1;
        if (stuck_cnt > 3000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic idx, logic [6:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        if (idx == pcs16_pkg::CFG_SAMPLE_BITS) cur_bits = data;
        else cur_float = data[0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (word_q.size() > 0 || i_in_valid || conv_q.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic run_phase(logic [6:0] bits, logic flt, int n_rand);
        write_reg(pcs16_pkg::CFG_SAMPLE_BITS, bits);
        write_reg(pcs16_pkg::CFG_FLOAT_SAMPLES, {6'($urandom_range(0, 63)), flt});
        // directed extremes and float specials
        word_q.push_back(64'h0);
        word_q.push_back('1);
        word_q.push_back(64'h8000_0000_0000_0000);
        word_q.push_back(64'h7FFF_FFFF_FFFF_FFFF);
        word_q.push_back(64'h5555_5555_AAAA_AAAA);
        word_q.push_back(64'hFFFF_FFFF_8000_0000);
        word_q.push_back(64'h0000_0000_7F80_0000);
        word_q.push_back(64'h0000_0000_FF80_0000);
        word_q.push_back(64'h0000_0000_7FC0_0001);
        word_q.push_back(64'h1234_5678_3F80_0000);
        word_q.push_back(64'h0000_0000_BF80_0000);
        word_q.push_back(64'h0000_0000_0000_0001);
        word_q.push_back(64'h3FF0_0000_0000_0000);
        word_q.push_back(64'hBFF0_0000_0000_0000);
        word_q.push_back(64'h7FF0_0000_0000_0000);
        word_q.push_back(64'hFFF0_0000_0000_0000);
        word_q.push_back(64'h7FF8_0000_0000_0001);
        word_q.push_back(64'h40E0_0000_0000_0000);
        word_q.push_back(64'h3FEF_FFFF_FFFF_FFFF);
        word_q.push_back(64'h0000_0000_3F7F_FFFF);
        repeat (n_rand) word_q.push_back(rand_word());
        drain();
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);
        // reset configuration first
        repeat (60) word_q.push_back(rand_word());
        hold_req = 1'b1;
        drain();
        run_phase(pcs16_pkg::BITS_8, 1'b0, 150);
        run_phase(pcs16_pkg::BITS_12, 1'b1, 100);
        no_idle = 1'b1;
        run_phase(pcs16_pkg::BITS_16, 1'b0, 150);
        no_idle = 1'b0;
        run_phase(pcs16_pkg::BITS_24, 1'b0, 150);
        run_phase(pcs16_pkg::BITS_32, 1'b0, 150);
        run_phase(pcs16_pkg::BITS_32, 1'b1, 350);
        no_idle = 1'b1;
        run_phase(pcs16_pkg::BITS_64, 1'b0, 200);
        no_idle = 1'b0;
        run_phase(pcs16_pkg::BITS_64, 1'b1, 200);
        run_phase(7'd0, 1'b0, 40);
        run_phase(7'd127, 1'b1, 40);
        run_phase(7'd33, 1'b1, 40);
        run_phase(7'($urandom_range(65, 126)), 1'b0, 40);
        run_phase(pcs16_pkg::BITS_32, 1'b1, 150);
        if (fail_cnt == 0 && conv_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== pcm_sample_to_int16.f =====
rtl/pcs16_pkg.sv
rtl/pcs16_decode.sv
rtl/pcs16_round.sv
rtl/pcs16_scale.sv
rtl/pcm_sample_to_int16.sv
rtl/pcs16_chk.sv
dv/pcm_sample_to_int16_tb.sv
